// ----- hw/rtl/fbpr_pkg.sv -----
package fbpr_pkg;

    localparam int FFT_N   = 2048;
    localparam int LOG2_N  = 11;
    localparam int QTR     = FFT_N / 4;
    localparam int ADDR_W  = LOG2_N;
    localparam int CNT_W   = LOG2_N + 1;
    localparam int BF_W    = LOG2_N - 1;
    localparam int STG_W   = $clog2(LOG2_N);
    localparam int TW_A_W  = LOG2_N - 1;
    localparam int TW_W    = 15;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 12;
    localparam int PADDR_W = 4;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TW_MAX = 64'd32767;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_SPLIT = 2'd1;
    localparam logic [1:0] REG_END   = 2'd2;

    typedef logic [TW_W-1:0] t_qsin [0:QTR];

    // sin(2*pi*q/N) in Q15, Taylor series in Q30
    function automatic logic [TW_W-1:0] qsine(input logic [63:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] r;
        x    = (PI_Q30 * 64'd2 * q + 64'(FFT_N / 2)) >> LOG2_N;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
        term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
        term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
        term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
        term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
        term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
        term = ((term * x2) >> 30) / 64'd210; neg = neg + term;
        term = ((term * x2) >> 30) / 64'd272; pos = pos + term;
        s = (neg > pos) ? 64'd0 : pos - neg;
        r = (s + 64'd16384) >> 15;
        if (r > TW_MAX) begin
            r = TW_MAX;
        end
        return r[TW_W-1:0];
    endfunction

    function automatic t_qsin build_qsin();
        t_qsin t;
        for (int i = 0; i <= QTR; i++) begin
            t[i] = qsine(64'(i));
        end
        return t;
    endfunction

    localparam t_qsin QSIN_TBL = build_qsin();

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_cplx;

endpackage

// ----- hw/rtl/fbpr_twiddle_rom.sv -----
module fbpr_twiddle_rom (
    input  logic                             i_clk,
    input  logic [fbpr_pkg::TW_A_W-1:0]      i_addr_s,
    input  logic [fbpr_pkg::TW_A_W-1:0]      i_addr_c,
    output logic [fbpr_pkg::TW_W-1:0]        o_qs,
    output logic [fbpr_pkg::TW_W-1:0]        o_qc
);

    // quarter-wave sine, two registered read ports
    always_ff @(posedge i_clk) begin
        o_qs <= fbpr_pkg::QSIN_TBL[i_addr_s];
        o_qc <= fbpr_pkg::QSIN_TBL[i_addr_c];
    end

endmodule

// ----- hw/rtl/fbpr_store.sv -----
module fbpr_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [fbpr_pkg::ADDR_W-1:0]   i_waddr,
    input  fbpr_pkg::t_cplx               i_wdata,
    input  logic [fbpr_pkg::ADDR_W-1:0]   i_raddr_a,
    input  logic [fbpr_pkg::ADDR_W-1:0]   i_raddr_b,
    output fbpr_pkg::t_cplx               o_rdata_a,
    output fbpr_pkg::t_cplx               o_rdata_b
);

    fbpr_pkg::t_cplx mem [fbpr_pkg::FFT_N];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ----- hw/rtl/fbpr_butterfly.sv -----
module fbpr_butterfly (
    input  logic                   i_clk,
    input  fbpr_pkg::t_cplx        i_a,
    input  fbpr_pkg::t_cplx        i_b,
    input  logic signed [16:0]     i_co,
    input  logic signed [16:0]     i_si,
    output fbpr_pkg::t_cplx        o_sum,
    output fbpr_pkg::t_cplx        o_dif
);

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // stage 1: products
    logic signed [48:0] r_p_rc, r_p_is, r_p_ic, r_p_rs;
    fbpr_pkg::t_cplx    r_a1;
    // stage 2: rounded twiddle product
    logic signed [34:0] r_tr, r_ti;
    fbpr_pkg::t_cplx    r_a2;

    logic signed [49:0] w_vr, w_vi;
    logic signed [49:0] w_rr, w_ri;
    logic signed [35:0] w_sr, w_si, w_dr, w_di;

    always_comb begin
        w_vr = 50'(r_p_rc) + 50'(r_p_is);
        w_vi = 50'(r_p_ic) - 50'(r_p_rs);
        w_rr = (w_vr + 50'sd16384) >>> 15;
        w_ri = (w_vi + 50'sd16384) >>> 15;
        w_sr = 36'(r_a2.re) + 36'(r_tr);
        w_si = 36'(r_a2.im) + 36'(r_ti);
        w_dr = 36'(r_a2.re) - 36'(r_tr);
        w_di = 36'(r_a2.im) - 36'(r_ti);
    end

    always_ff @(posedge i_clk) begin
        r_p_rc   <= 49'(i_b.re) * 49'(i_co);
        r_p_is   <= 49'(i_b.im) * 49'(i_si);
        r_p_ic   <= 49'(i_b.im) * 49'(i_co);
        r_p_rs   <= 49'(i_b.re) * 49'(i_si);
        r_a1     <= i_a;
        r_tr     <= w_rr[34:0];
        r_ti     <= w_ri[34:0];
        r_a2     <= r_a1;
        o_sum.re <= sat32(w_sr);
        o_sum.im <= sat32(w_si);
        o_dif.re <= sat32(w_dr);
        o_dif.im <= sat32(w_di);
    end

endmodule

// ----- hw/rtl/fft_band_power_ratio_top.sv -----
// Band power ratio of one frame by a 2048-point fixed-point radix-2 FFT.
// Samples are taken one per cycle while loading; each is written to the
// sample store at its bit-reversed address, so no reordering pass is needed,
// and samples past 2048 are dropped and flagged. The request carrying
// frame_end starts the transform: 11 stages of 1024 butterflies, each
// butterfly writing its two results one after the other through the single
// write port of the store. The power pass then reads one bin per cycle over
// [band_start_bin, band_end_bin), the end capped at 2048, and drains its
// pipeline; the ratio divider retires one quotient bit per cycle. After the
// result is registered, a clearing pass zeroes the store; the same pass
// runs after reset. No sample is taken outside the loading phase;
// configuration writes are taken at any time. A finished result waits in
// the output register while the next frame loads.
module fft_band_power_ratio_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [15:0]                 i_sample,
    input  logic                               i_frame_end,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [15:0]                        o_band_ratio,
    output logic                               o_zero_power,
    output logic                               o_samples_dropped,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fbpr_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int ADDR_W = fbpr_pkg::ADDR_W;
    localparam int CNT_W  = fbpr_pkg::CNT_W;
    localparam int BF_W   = fbpr_pkg::BF_W;
    localparam int STG_W  = fbpr_pkg::STG_W;
    localparam int TA_W   = fbpr_pkg::TW_A_W;
    localparam int CFG_W  = fbpr_pkg::CFG_W;
    localparam int LOG2_LAST = fbpr_pkg::LOG2_N - 1;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_LOAD   = 12'b0000_0000_0010,
        S_BF_RD  = 12'b0000_0000_0100,
        S_BF_MUL = 12'b0000_0000_1000,
        S_BF_RND = 12'b0000_0001_0000,
        S_BF_SAT = 12'b0000_0010_0000,
        S_BF_WB  = 12'b0000_0100_0000,
        S_BF_WA  = 12'b0000_1000_0000,
        S_PWR    = 12'b0001_0000_0000,
        S_DRAIN  = 12'b0010_0000_0000,
        S_DIV    = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_W-1:0] r_start, r_split, r_end;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= CFG_W'(5);
            r_split <= CFG_W'(16);
            r_end   <= CFG_W'(41);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                fbpr_pkg::REG_START: r_start <= pwdata[CFG_W-1:0];
                fbpr_pkg::REG_SPLIT: r_split <= pwdata[CFG_W-1:0];
                fbpr_pkg::REG_END:   r_end   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fbpr_pkg::REG_START: prdata = 32'(r_start);
            fbpr_pkg::REG_SPLIT: prdata = 32'(r_split);
            fbpr_pkg::REG_END:   prdata = 32'(r_end);
            default:             prdata = 32'd0;
        endcase
    end

    // frame loading
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [ADDR_W-1:0] r_clr;
    logic              w_in_acc;
    logic [ADDR_W-1:0] w_brev;

    assign o_stall  = (r_state != S_LOAD);
    assign w_in_acc = i_valid && !o_stall;

    always_comb begin
        for (int b = 0; b < ADDR_W; b++) begin
            w_brev[b] = r_count[ADDR_W-1-b];
        end
    end

    // butterfly addressing: insert a zero at bit "stage" of the index
    logic [STG_W-1:0]  r_stage;
    logic [BF_W-1:0]   r_bf;
    logic [BF_W-1:0]   w_mask;
    logic [ADDR_W-1:0] w_addr_a, w_addr_b;
    logic [TA_W-1:0]   w_p;
    logic [TA_W:0]     w_p_ext;
    logic [TA_W-1:0]   w_ta_s, w_ta_c;
    logic              w_neg;
    logic              r_neg;

    always_comb begin
        w_mask   = (BF_W'(1) << r_stage) - BF_W'(1);
        w_addr_a = {r_bf & ~w_mask, 1'b0} | {1'b0, r_bf & w_mask};
        w_addr_b = w_addr_a | (ADDR_W'(1) << r_stage);
        w_p      = (r_bf & w_mask) << (STG_W'(BF_W) - r_stage);
        w_p_ext  = {1'b0, w_p};
        if (w_p_ext <= (TA_W + 1)'(fbpr_pkg::QTR)) begin
            w_ta_s = w_p;
            w_ta_c = TA_W'((TA_W + 1)'(fbpr_pkg::QTR) - w_p_ext);
            w_neg  = 1'b0;
        end else begin
            w_ta_s = TA_W'((TA_W + 1)'(2 * fbpr_pkg::QTR) - w_p_ext);
            w_ta_c = TA_W'(w_p_ext - (TA_W + 1)'(fbpr_pkg::QTR));
            w_neg  = 1'b1;
        end
    end

    // twiddle table and store
    logic [fbpr_pkg::TW_W-1:0] w_qs, w_qc;
    logic signed [16:0]        w_co, w_si;

    fbpr_twiddle_rom u_rom (
        .i_clk    (i_clk),
        .i_addr_s (w_ta_s),
        .i_addr_c (w_ta_c),
        .o_qs     (w_qs),
        .o_qc     (w_qc)
    );

    assign w_si = 17'(w_qs);
    assign w_co = r_neg ? -17'(w_qc) : 17'(w_qc);

    logic [CFG_W-1:0]  r_k;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr_a;
    fbpr_pkg::t_cplx   w_wdata, w_rd_a, w_rd_b, w_sum, w_dif;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_LOAD: begin
                w_we       = w_in_acc && (r_count < CNT_W'(fbpr_pkg::FFT_N));
                w_waddr    = w_brev;
                w_wdata.re = 32'(i_sample);
            end
            S_BF_WB: begin
                w_we    = 1'b1;
                w_waddr = w_addr_b;
                w_wdata = w_dif;
            end
            S_BF_WA: begin
                w_we    = 1'b1;
                w_waddr = w_addr_a;
                w_wdata = w_sum;
            end
            default: ;
        endcase
        w_raddr_a = (r_state == S_PWR) ? r_k[ADDR_W-1:0] : w_addr_a;
    end

    fbpr_store u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    fbpr_butterfly u_bf (
        .i_clk (i_clk),
        .i_a   (w_rd_a),
        .i_b   (w_rd_b),
        .i_co  (w_co),
        .i_si  (w_si),
        .o_sum (w_sum),
        .o_dif (w_dif)
    );

    // power pipeline: read, square, add, accumulate
    logic         r_pv0, r_pv1, r_pv2;
    logic         r_pl0, r_pl1, r_pl2;
    logic [63:0]  r_re2, r_im2, r_pw;
    logic [63:0]  r_high, r_low;
    logic signed [63:0] w_re2, w_im2;
    logic [64:0]  w_hsum, w_lsum;
    logic         w_k_run;

    assign w_re2   = 64'(w_rd_a.re) * 64'(w_rd_a.re);
    assign w_im2   = 64'(w_rd_a.im) * 64'(w_rd_a.im);
    assign w_hsum  = {1'b0, r_high} + {1'b0, r_pw};
    assign w_lsum  = {1'b0, r_low} + {1'b0, r_pw};
    assign w_k_run = (r_k < r_end) && (r_k < CFG_W'(fbpr_pkg::FFT_N));

    always_ff @(posedge i_clk) begin
        r_re2 <= w_re2;
        r_im2 <= w_im2;
        r_pw  <= r_re2 + r_im2;
        r_pl1 <= r_pl0;
        r_pl2 <= r_pl1;
    end

    // ratio divider, one quotient bit per cycle
    logic [63:0] r_rem;
    logic [15:0] r_q;
    logic [3:0]  r_n;
    logic        r_zero;
    logic [64:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_high});

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_stage       <= '0;
            r_bf          <= '0;
            r_pv0         <= 1'b0;
            r_pv1         <= 1'b0;
            r_pv2         <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            r_pv0 <= 1'b0;
            r_pv1 <= r_pv0;
            r_pv2 <= r_pv1;
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == '1) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count < CNT_W'(fbpr_pkg::FFT_N)) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_frame_end) begin
                            r_stage <= '0;
                            r_bf    <= '0;
                            r_state <= S_BF_RD;
                        end
                    end
                end
                S_BF_RD:  r_state <= S_BF_MUL;
                S_BF_MUL: r_state <= S_BF_RND;
                S_BF_RND: r_state <= S_BF_SAT;
                S_BF_SAT: r_state <= S_BF_WB;
                S_BF_WB:  r_state <= S_BF_WA;
                S_BF_WA: begin
                    r_bf    <= r_bf + BF_W'(1);
                    r_state <= S_BF_RD;
                    if (r_bf == '1) begin
                        r_stage <= r_stage + STG_W'(1);
                        if (r_stage == STG_W'(LOG2_LAST)) begin
                            r_state <= S_PWR;
                        end
                    end
                end
                S_PWR: begin
                    if (w_k_run) begin
                        r_pv0 <= 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_pv0 && !r_pv1 && !r_pv2) begin
                        r_state <= (r_high != 64'd0 && r_low < r_high) ? S_DIV : S_OUT;
                    end
                end
                S_DIV: begin
                    if (r_n == 4'hF) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_clr   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge i_clk) begin
        r_neg <= w_neg;
        r_pl0 <= (r_k < r_split);
        if (r_state == S_BF_WA && r_bf == '1 && r_stage == STG_W'(LOG2_LAST)) begin
            r_k    <= r_start;
            r_high <= '0;
            r_low  <= '0;
        end else if (r_state == S_PWR && w_k_run) begin
            r_k <= r_k + CFG_W'(1);
        end
        if (r_pv2) begin
            r_high <= w_hsum[64] ? '1 : w_hsum[63:0];
            if (r_pl2) begin
                r_low <= w_lsum[64] ? '1 : w_lsum[63:0];
            end
        end
        if (r_state == S_DRAIN) begin
            r_rem  <= r_low;
            r_q    <= (r_high != 64'd0 && r_low >= r_high) ? 16'hFFFF : 16'd0;
            r_zero <= (r_high == 64'd0);
            r_n    <= '0;
        end else if (r_state == S_DIV) begin
            r_q <= {r_q[14:0], w_ge};
            r_n <= r_n + 4'd1;
            if (w_ge) begin
                r_rem <= 64'(w_rem2 - {1'b0, r_high});
            end else begin
                r_rem <= w_rem2[63:0];
            end
        end
        if (r_state == S_OUT && !o_valid) begin
            o_band_ratio      <= r_q;
            o_zero_power      <= r_zero;
            o_samples_dropped <= r_ovf;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(fbpr_pkg::FFT_N))
        else $error("sample count past transform size");

    a_no_write_in_pwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PWR || r_state == S_DRAIN || r_state == S_DIV) |-> !w_we)
        else $error("store written during power or divide phase");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside output phase");

    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CLEAR && r_state == S_LOAD) |-> (r_count == '0 && !r_ovf))
        else $error("frame state not cleared before loading");

endmodule
